// File: hw/rtl/ksls_pkg.sv
// Shared types and constants for the keyed shift list store.
// No dependencies; used by every module of the block.
`default_nettype none

package ksls_pkg;

  localparam int DEPTH_DEF    = 16;
  localparam int KEY_BITS_DEF = 16;

  localparam int CAP_W    = 5;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 4;
  localparam int COUNT_W  = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic    load;
    logic    insert;
    logic    scan_start;
    logic    scan_step;
    logic    close;
    logic    emit;
    status_t code;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_remove;
    logic full;
    logic empty;
    logic hit;
    logic last;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/keyed_shift_list_store_top.sv
// Top level of the keyed shift list store: controller plus datapath.
// Depends on ksls_pkg, ksls_ctrl and ksls_datapath.
//
//   port group   dir   handshake              word
//   cfg          in    cfg_valid / cfg_ready  cfg_data (capacity)
//   in           in    in_valid / in_stall    opcode, item_key
//   out          out   out_valid / out_stall  status, found_position, entry_count
//
// One request at a time. Insert, and remove on an empty list: the result is
// registered from the execute state, and the next word is taken back in idle.
// Remove walks the list with one comparator, one slot per cycle: a hit passes
// through the close state before its result is registered, a miss ends at the
// last entry. A held result stalls the next one only at its final step.
// Synchronous reset empties the list and restores capacity to 16;
// cfg_ready is always high.
`default_nettype none

module keyed_shift_list_store_top #(
  parameter int DEPTH    = ksls_pkg::DEPTH_DEF,
  parameter int KEY_BITS = ksls_pkg::KEY_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [ksls_pkg::CAP_W-1:0]    cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          opcode,
  input  wire logic [KEY_BITS-1:0]           item_key,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [ksls_pkg::STATUS_W-1:0]      status,
  output logic [ksls_pkg::POS_W-1:0]         found_position,
  output logic [ksls_pkg::COUNT_W-1:0]       entry_count
);

  ksls_pkg::ctrl_cmd_t cmd;
  ksls_pkg::dp_stat_t  stat;

  assign cfg_ready = 1'b1;

  ksls_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  ksls_datapath #(
    .DEPTH    (DEPTH),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr         (cfg_valid && cfg_ready),
    .cfg_data       (cfg_data),
    .opcode         (opcode),
    .item_key       (item_key),
    .cmd            (cmd),
    .stat           (stat),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .status         (status),
    .found_position (found_position),
    .entry_count    (entry_count)
  );

endmodule

`default_nettype wire

// File: hw/rtl/ksls_ctrl.sv
// Sequencer for the keyed shift list store: accepts requests and steps
// the datapath through insert, scan and close. Depends on ksls_pkg.
`default_nettype none

module ksls_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire ksls_pkg::dp_stat_t  stat,
  output ksls_pkg::ctrl_cmd_t      cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_CLOSE
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.code       = ksls_pkg::ST_DONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!stat.is_remove) begin
          if (stat.out_free) begin
            cmd.emit   = 1'b1;
            state_next = S_IDLE;
            if (stat.full) begin
              cmd.code = ksls_pkg::ST_FULL;
            end else begin
              cmd.insert = 1'b1;
            end
          end
        end else if (stat.empty) begin
          if (stat.out_free) begin
            cmd.emit   = 1'b1;
            cmd.code   = ksls_pkg::ST_EMPTY;
            state_next = S_IDLE;
          end
        end else begin
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.hit) begin
          state_next = S_CLOSE;        // scan index now holds the hit position
        end else if (stat.last) begin
          if (stat.out_free) begin
            cmd.emit   = 1'b1;
            cmd.code   = ksls_pkg::ST_MISSING;
            state_next = S_IDLE;
          end
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_CLOSE: begin
        if (stat.out_free) begin
          cmd.close  = 1'b1;
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/ksls_datapath.sv
// Datapath of the keyed shift list store: row of key cells, count, scan
// pointer, capacity register and result register. Depends on ksls_pkg.
`default_nettype none

module ksls_datapath #(
  parameter int DEPTH    = ksls_pkg::DEPTH_DEF,
  parameter int KEY_BITS = ksls_pkg::KEY_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_wr,
  input  wire logic [ksls_pkg::CAP_W-1:0]    cfg_data,
  input  wire logic                          opcode,
  input  wire logic [KEY_BITS-1:0]           item_key,
  input  wire ksls_pkg::ctrl_cmd_t           cmd,
  output ksls_pkg::dp_stat_t                 stat,
  input  wire logic                          out_stall,
  output logic                               out_valid,
  output logic [ksls_pkg::STATUS_W-1:0]      status,
  output logic [ksls_pkg::POS_W-1:0]         found_position,
  output logic [ksls_pkg::COUNT_W-1:0]       entry_count
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > ksls_pkg::CAP_W) ? CNT_W : ksls_pkg::CAP_W;

  logic [KEY_BITS-1:0]        slots [DEPTH];
  logic [CNT_W-1:0]           held;
  logic [CNT_W-1:0]           held_next;
  logic [ksls_pkg::CAP_W-1:0] capacity;
  logic [IDX_W-1:0]           scan;
  logic [KEY_BITS-1:0]        key_r;
  ksls_pkg::op_t              op_r;

  always_comb begin
    held_next = held;
    if (cmd.insert) begin
      held_next = held + CNT_W'(1);
    end else if (cmd.close) begin
      held_next = held - CNT_W'(1);
    end
  end

  assign stat.is_remove = (op_r == ksls_pkg::OP_REMOVE);
  assign stat.full      = (CMP_W'(held) >= CMP_W'(capacity)) || (held == CNT_W'(DEPTH));
  assign stat.empty     = (held == '0);
  assign stat.hit       = (slots[scan] == key_r);
  assign stat.last      = ((CNT_W'(scan) + CNT_W'(1)) == held);
  assign stat.out_free  = !out_valid || !out_stall;

  // key cells: shift back on insert, close the gap at the scan point on remove
  always_ff @(posedge clk) begin
    for (int k = 0; k < DEPTH; k++) begin
      if (cmd.insert) begin
        if (k == 0) begin
          slots[k] <= key_r;
        end else begin
          slots[k] <= slots[k-1];
        end
      end else if (cmd.close && (k < DEPTH - 1) && (IDX_W'(k) >= scan)) begin
        slots[k] <= slots[k+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r <= item_key;
      op_r  <= ksls_pkg::op_t'(opcode);
    end
    if (cmd.scan_start) begin
      scan <= '0;
    end else if (cmd.scan_step) begin
      scan <= scan + IDX_W'(1);
    end
    if (cmd.emit) begin
      status         <= cmd.code;
      found_position <= cmd.close ? ksls_pkg::POS_W'(scan) : '0;
      entry_count    <= ksls_pkg::COUNT_W'(held_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held      <= '0;
      capacity  <= ksls_pkg::CAP_RESET;
      out_valid <= 1'b0;
    end else begin
      held <= held_next;
      if (cfg_wr) begin
        capacity <= cfg_data;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/ksls_checker.sv
// Port-level checks for the keyed shift list store, bound to the top level.
// Depends on ksls_pkg.
`default_nettype none

module ksls_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_stall,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic [ksls_pkg::STATUS_W-1:0] status,
  input wire logic [ksls_pkg::POS_W-1:0]    found_position,
  input wire logic [ksls_pkg::COUNT_W-1:0]  entry_count
);

  // result word holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) &&
      $stable(found_position) && $stable(entry_count))
    else $error("result word changed under stall");

  // only a successful remove reports a position
  a_pos_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ksls_pkg::ST_DONE) |-> found_position == '0)
    else $error("position set on a result other than done");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ksls_pkg::ST_EMPTY) |-> entry_count == '0)
    else $error("empty report with nonzero count");

  // one request at a time: busy right after a word is taken
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while previous one still in flight");

endmodule

bind keyed_shift_list_store_top ksls_checker u_ksls_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .status         (status),
  .found_position (found_position),
  .entry_count    (entry_count)
);

`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for keyed_shift_list_store_top: insert/remove traffic against
// a local list predictor, random gaps and stalls on both channels.
// Depends on ksls_pkg and the keyed_shift_list_store_top RTL.
`timescale 1ns / 100ps

module tb_top;

  localparam int LIST_DEPTH = ksls_pkg::DEPTH_DEF;
  localparam int KEY_W      = ksls_pkg::KEY_BITS_DEF;

  typedef struct {
    ksls_pkg::status_t                status;
    logic [ksls_pkg::POS_W-1:0]       pos;
    logic [ksls_pkg::COUNT_W-1:0]     count;
  } list_reply_t;

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [ksls_pkg::CAP_W-1:0]    cfg_data;
  logic                          in_valid;
  logic                          in_stall;
  logic                          opcode;
  logic [KEY_W-1:0]              item_key;
  logic                          out_valid;
  logic                          out_stall;
  logic [ksls_pkg::STATUS_W-1:0] status;
  logic [ksls_pkg::POS_W-1:0]    found_position;
  logic [ksls_pkg::COUNT_W-1:0]  entry_count;

  // predictor state
  logic [KEY_W-1:0]    list_keys [LIST_DEPTH];
  int                  list_len;
  int                  list_cap;
  list_reply_t         pending_replies [$];

  int                  fail_count;
  int                  in_gap_max;
  int                  out_stall_max;
  int                  hold_request;

  always #5 clk = ~clk;

  keyed_shift_list_store_top u_top (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .opcode         (opcode),
    .item_key       (item_key),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .found_position (found_position),
    .entry_count    (entry_count)
  );

  function automatic void apply_list_request(input ksls_pkg::op_t op,
                                             input logic [KEY_W-1:0] key);
    list_reply_t r;
    int lim;
    int hit_at;
    r.status = ksls_pkg::ST_DONE;
    r.pos    = '0;
    lim = (list_cap > LIST_DEPTH) ? LIST_DEPTH : list_cap;
    if (op == ksls_pkg::OP_INSERT) begin
      if (list_len >= lim) begin
        r.status = ksls_pkg::ST_FULL;
      end else begin
        for (int k = list_len; k > 0; k--) list_keys[k] = list_keys[k-1];
        list_keys[0] = key;
        list_len++;
      end
    end else if (list_len == 0) begin
      r.status = ksls_pkg::ST_EMPTY;
    end else begin
      hit_at = -1;
      for (int k = 0; k < list_len; k++)
        if (hit_at < 0 && list_keys[k] == key) hit_at = k;
      if (hit_at < 0) begin
        r.status = ksls_pkg::ST_MISSING;
      end else begin
        r.pos = hit_at[ksls_pkg::POS_W-1:0];
        for (int k = hit_at; k + 1 < list_len; k++) list_keys[k] = list_keys[k+1];
        list_len--;
      end
    end
    r.count = list_len[ksls_pkg::COUNT_W-1:0];
    pending_replies.push_back(r);
  endfunction

  function automatic void report_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  function automatic void check_reply();
    list_reply_t exp_r;
    if (pending_replies.size() == 0) begin
      $display("%0t: unexpected reply word, expected none actual status %0d pos %0d count %0d",
               $time, status, found_position, entry_count);
      fail_count++;
    end else begin
      exp_r = pending_replies.pop_front();
      report_field("status", exp_r.status, status);
      report_field("found_position", exp_r.pos, found_position);
      report_field("entry_count", exp_r.count, entry_count);
    end
  endfunction

  // Caller either sends again or calls wait_for_replies in the same step,
  // so in_valid is never lowered and raised within one step.
  task automatic send_word(input ksls_pkg::op_t op, input logic [KEY_W-1:0] key);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    item_key <= key;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_list_request(op, key);
  endtask

  task automatic wait_for_replies();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [ksls_pkg::CAP_W-1:0] value);
    wait_for_replies();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    list_cap = value;
  endtask

  task automatic run_list_traffic(input int n, input int insert_pct, input bit narrow_keys);
    ksls_pkg::op_t op;
    logic [KEY_W-1:0] key;
    for (int i = 0; i < n; i++) begin
      op = ($urandom_range(0, 99) < insert_pct) ? ksls_pkg::OP_INSERT : ksls_pkg::OP_REMOVE;
      key = narrow_keys ? KEY_W'($urandom_range(0, 7)) : KEY_W'($urandom);
      // mostly remove something that is really held
      if (op == ksls_pkg::OP_REMOVE && list_len > 0 && $urandom_range(0, 9) < 8)
        key = list_keys[$urandom_range(0, list_len - 1)];
      send_word(op, key);
    end
  endtask

  task automatic test_empty_and_extremes();
    in_gap_max    = 2;
    out_stall_max = 2;
    send_word(ksls_pkg::OP_REMOVE, 16'h0000);   // empty list
    send_word(ksls_pkg::OP_INSERT, 16'h0000);
    send_word(ksls_pkg::OP_INSERT, 16'hFFFF);
    send_word(ksls_pkg::OP_INSERT, 16'hFFFF);   // duplicate
    send_word(ksls_pkg::OP_REMOVE, 16'hFFFF);   // front copy goes first
    send_word(ksls_pkg::OP_REMOVE, 16'hAAAA);   // absent
    send_word(ksls_pkg::OP_INSERT, 16'h5555);
    send_word(ksls_pkg::OP_REMOVE, 16'h0000);   // deepest entry
    send_word(ksls_pkg::OP_REMOVE, 16'hFFFF);
    send_word(ksls_pkg::OP_REMOVE, 16'h5555);
    send_word(ksls_pkg::OP_REMOVE, 16'h5555);   // empty again
    wait_for_replies();
  endtask

  task automatic test_capacity_edges();
    write_capacity(5'd1);
    send_word(ksls_pkg::OP_INSERT, 16'h1234);
    send_word(ksls_pkg::OP_INSERT, 16'h4321);   // full at one
    write_capacity(5'd0);
    send_word(ksls_pkg::OP_INSERT, 16'h0F0F);   // zero capacity: always full
    send_word(ksls_pkg::OP_REMOVE, 16'h1234);   // removes still work
    // capacity dropped below the current count
    write_capacity(5'd16);
    send_word(ksls_pkg::OP_INSERT, 16'h00A1);
    send_word(ksls_pkg::OP_INSERT, 16'h00B2);
    send_word(ksls_pkg::OP_INSERT, 16'h00C3);
    write_capacity(5'd2);
    send_word(ksls_pkg::OP_INSERT, 16'h00D4);
    send_word(ksls_pkg::OP_REMOVE, 16'h00B2);
    send_word(ksls_pkg::OP_INSERT, 16'h00E5);
    wait_for_replies();
  endtask

  task automatic test_fill_to_depth();
    write_capacity(5'd31);            // above depth, clamps
    in_gap_max    = 0;
    out_stall_max = 0;
    while (list_len < LIST_DEPTH) send_word(ksls_pkg::OP_INSERT, KEY_W'($urandom));
    send_word(ksls_pkg::OP_INSERT, KEY_W'($urandom));
    send_word(ksls_pkg::OP_REMOVE, list_keys[LIST_DEPTH-1]);
    while (list_len > 0)
      send_word(ksls_pkg::OP_REMOVE, list_keys[$urandom_range(0, list_len - 1)]);
    wait_for_replies();
  endtask

  task automatic test_output_backpressure();
    write_capacity(5'd16);
    in_gap_max    = 0;
    out_stall_max = 0;
    hold_request  = 300;
    run_list_traffic(14, 70, 1'b0);
    wait_for_replies();
  endtask

  task automatic test_random_traffic();
    int caps [8];
    int pace;
    caps = '{16, 5, 31, 1, 2, 9, 0, 16};
    caps[6] = $urandom_range(0, 31);
    for (int ph = 0; ph < 8; ph++) begin
      write_capacity(caps[ph][ksls_pkg::CAP_W-1:0]);
      pace = $urandom_range(0, 2);
      in_gap_max    = (pace == 0) ? 0 : (pace == 1) ? 3 : 16;
      pace = $urandom_range(0, 2);
      out_stall_max = (pace == 0) ? 0 : (pace == 1) ? 3 : 16;
      run_list_traffic(50, (ph % 2 == 0) ? 72 : 45, ph % 3 == 1);
      wait_for_replies();
    end
  endtask

  initial begin : reply_monitor
    int hold;
    out_stall <= 1'b0;
    @(negedge rst);
    forever begin
      if (hold_request > 0) begin
        hold = hold_request;
        hold_request = 0;
      end else begin
        hold = $urandom_range(0, out_stall_max);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      check_reply();
    end
  end

  initial begin : run_limit
    #3_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    fail_count    = 0;
    hold_request  = 0;
    in_gap_max    = 0;
    out_stall_max = 0;
    list_len      = 0;
    list_cap      = ksls_pkg::CAP_RESET;
    rst       <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    opcode    <= ksls_pkg::OP_INSERT;
    item_key  <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    test_empty_and_extremes();
    test_capacity_edges();
    test_fill_to_depth();
    test_output_backpressure();
    test_random_traffic();

    wait_for_replies();
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
